FILE: src/bounded_doubly_linked_list_unit_assert.svh
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_unit_assert
// Assertion macros used by the list unit.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH
// Implication checked at every rising clock edge, disabled while reset is asserted.
`define BDL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/bdll_pkg.sv
// ----------------------------------------------------------------------------
// bdll_pkg
// Shared constants, opcodes and status codes of the linked list unit.
// ----------------------------------------------------------------------------
package bdll_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    localparam int ValW = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_GET        = 3'd6;
    localparam logic [2:0] OP_SIZE       = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // One access to the node store.
    typedef struct packed {
        logic            rd_en;
        logic [IdxW-1:0] rd_addr;
        logic            val_we;
        logic [IdxW-1:0] val_addr;
        logic [ValW-1:0] val_data;
        logic            nxt_we;
        logic [IdxW-1:0] nxt_addr;
        logic [IdxW-1:0] nxt_data;
        logic            prv_we;
        logic [IdxW-1:0] prv_addr;
        logic [IdxW-1:0] prv_data;
    } store_req_t;

    typedef struct packed {
        logic [ValW-1:0] value;
        logic [IdxW-1:0] nxt;
        logic [IdxW-1:0] prv;
    } store_rsp_t;
endpackage

FILE: src/bdll_store.sv
// ----------------------------------------------------------------------------
// bdll_store
// Node store: value, forward link and backward link memories sharing a
// read address, each with its own write port. Read data is registered.
// ----------------------------------------------------------------------------
module bdll_store
    import bdll_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output store_rsp_t rsp
);
    logic [ValW-1:0] val_mem [Capacity];
    logic [IdxW-1:0] nxt_mem [Capacity];
    logic [IdxW-1:0] prv_mem [Capacity];

    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.val_addr] <= req.val_data;
        end
        if (req.nxt_we)
        begin
            nxt_mem[req.nxt_addr] <= req.nxt_data;
        end
        if (req.prv_we)
        begin
            prv_mem[req.prv_addr] <= req.prv_data;
        end
        if (req.rd_en)
        begin
            rsp.value <= val_mem[req.rd_addr];
            rsp.nxt   <= nxt_mem[req.rd_addr];
            rsp.prv   <= prv_mem[req.rd_addr];
        end
    end
endmodule

FILE: src/bounded_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_unit
// Bounded doubly linked list of signed 32-bit values with a free list.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_axis (opcode, operand_value, position)
// and exactly one result beat leaves on m_axis (read_value, status,
// element_count). Commands are processed one at a time.
// Steps from command accept to result valid:
//   size and failed ops go straight to the result; push reads the free
//   head, then links the new node; pop reads the end node, then unlinks it;
//   get and remove walk from the front (an absent value walks the whole
//   list); every node visit is one read of the node store and a wait for
//   the registered read data. clear: one free link rewritten per cycle.
// After reset the free list is rechained by the same sweep, during
// which s_axis_tready stays low.
// The result sits in an output register; a new command is taken while it
// waits, and the next result is held back until the receiver takes it.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_unit
    import bdll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [34:3] operand_value, [40:35] position, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_value, [34:32] status, [41:35] element_count, [47:42] zero
    output logic [47:0] m_axis_tdata
);
    `include "bounded_doubly_linked_list_unit_assert.svh"

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TAKE  = 4'd2;  // read free head node
    localparam logic [3:0] S_PUSH  = 4'd3;  // link new node
    localparam logic [3:0] S_POPW  = 4'd4;  // wait for end node read
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;  // read issued, wait
    localparam logic [3:0] S_VISIT = 4'd7;  // data available
    localparam logic [3:0] S_DONE  = 4'd8;  // result ready to emit

    logic [3:0]      state_reg, state_next;
    logic [IdxW-1:0] sweep_reg, sweep_next;
    logic [IdxW-1:0] front_reg, front_next;
    logic [IdxW-1:0] back_reg, back_next;
    logic [IdxW-1:0] free_reg, free_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [2:0]      op_reg, op_next;
    logic [ValW-1:0] arg_reg, arg_next;
    logic [IdxW-1:0] pos_reg, pos_next;
    logic [IdxW-1:0] cur_reg, cur_next;
    logic [CntW-1:0] k_reg, k_next;
    logic [ValW-1:0] rv_reg, rv_next;
    logic [2:0]      st_reg, st_next;
    logic            ov_reg, ov_next;
    logic [47:0]     od_reg, od_next;

    store_req_t req;
    store_rsp_t rsp;

    bdll_store u_store (.clk(clk), .req(req), .rsp(rsp));

    logic            in_fire;
    logic [2:0]      in_op;
    logic [ValW-1:0] in_val;
    logic [IdxW-1:0] in_pos;
    logic            last_node;

    assign in_op  = s_axis_tdata[2:0];
    assign in_val = s_axis_tdata[34:3];
    assign in_pos = s_axis_tdata[35 +: IdxW];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign last_node = (sweep_reg == IdxW'(Capacity - 1));

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        front_next = front_reg;
        back_next  = back_reg;
        free_next  = free_reg;
        count_next = count_reg;
        op_next    = op_reg;
        arg_next   = arg_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        rv_next    = rv_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        req        = '0;

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                req.nxt_we   = 1'b1;
                req.nxt_addr = sweep_reg;
                req.nxt_data = last_node ? '0 : sweep_reg + 1'b1;
                sweep_next   = sweep_reg + 1'b1;
                if (last_node)
                begin
                    state_next = (op_reg == OP_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = in_op;
                    arg_next = in_val;
                    pos_next = in_pos;
                    rv_next  = '0;
                    st_next  = ST_OK;
                    k_next   = '0;
                    cur_next = front_reg;
                    state_next = S_DONE;
                    case (in_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (count_reg >= CntW'(Capacity))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = free_reg;
                                state_next  = S_TAKE;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = (in_op == OP_POP_FRONT) ? front_reg : back_reg;
                                state_next  = S_POPW;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = front_reg;
                                state_next  = S_WALK;
                            end
                        end
                        OP_GET:
                        begin
                            if (CntW'(in_pos) >= count_reg)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = front_reg;
                                state_next  = S_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            sweep_next = '0;
                            front_next = '0;
                            back_next  = '0;
                            free_next  = '0;
                            count_next = '0;
                            state_next = S_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TAKE:
            begin
                // New node is free_reg; its forward link is the next free node.
                free_next    = rsp.nxt;
                req.val_we   = 1'b1;
                req.val_addr = free_reg;
                req.val_data = arg_reg;
                cur_next     = free_reg;
                state_next   = S_PUSH;
            end
            S_PUSH:
            begin
                if (count_reg == '0)
                begin
                    front_next = cur_reg;
                    back_next  = cur_reg;
                end
                else if (op_reg == OP_PUSH_FRONT)
                begin
                    req.nxt_we   = 1'b1;
                    req.nxt_addr = cur_reg;
                    req.nxt_data = front_reg;
                    req.prv_we   = 1'b1;
                    req.prv_addr = front_reg;
                    req.prv_data = cur_reg;
                    front_next   = cur_reg;
                end
                else
                begin
                    req.prv_we   = 1'b1;
                    req.prv_addr = cur_reg;
                    req.prv_data = back_reg;
                    req.nxt_we   = 1'b1;
                    req.nxt_addr = back_reg;
                    req.nxt_data = cur_reg;
                    back_next    = cur_reg;
                end
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_POPW:
            begin
                state_next = S_POP;
                // Read data is already valid here and stays held for the pop.
                cur_next = (op_reg == OP_POP_FRONT) ? front_reg : back_reg;
            end
            S_POP:
            begin
                if (op_reg == OP_POP_FRONT)
                begin
                    front_next = rsp.nxt;
                end
                else
                begin
                    back_next = rsp.prv;
                end
                req.nxt_we   = 1'b1;
                req.nxt_addr = cur_reg;
                req.nxt_data = free_reg;
                free_next    = cur_reg;
                count_next   = count_reg - 1'b1;
                state_next   = S_DONE;
            end
            S_WALK:
            begin
                state_next = S_VISIT;
            end
            S_VISIT:
            begin
                if (op_reg == OP_GET)
                begin
                    if (k_reg == CntW'(pos_reg))
                    begin
                        rv_next    = rsp.value;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = rsp.nxt;
                        cur_next    = rsp.nxt;
                        k_next      = k_reg + 1'b1;
                        state_next  = S_WALK;
                    end
                end
                else if (rsp.value == arg_reg)
                begin
                    if (count_reg == CntW'(1))
                    begin
                        front_next = '0;
                        back_next  = '0;
                    end
                    else if (k_reg == '0)
                    begin
                        front_next = rsp.nxt;
                    end
                    else if (k_reg == count_reg - 1'b1)
                    begin
                        back_next = rsp.prv;
                    end
                    else
                    begin
                        req.nxt_we   = 1'b1;
                        req.nxt_addr = rsp.prv;
                        req.nxt_data = rsp.nxt;
                        req.prv_we   = 1'b1;
                        req.prv_addr = rsp.nxt;
                        req.prv_data = rsp.prv;
                    end
                    // Freed node goes to the head of the free list; its
                    // forward link is written next cycle from the old free
                    // head, which is kept in pos_reg meanwhile.
                    pos_next   = free_reg;
                    free_next  = cur_reg;
                    count_next = count_reg - 1'b1;
                    state_next = S_POP;
                    op_next    = OP_REMOVE;
                end
                else if (k_reg == count_reg - 1'b1)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rsp.nxt;
                    cur_next    = rsp.nxt;
                    k_next      = k_reg + 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {6'd0, 7'(count_reg), st_reg, rv_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Remove finishes through the pop state only to free the node.
        if (state_reg == S_POP && op_reg == OP_REMOVE)
        begin
            front_next = front_reg;
            back_next  = back_reg;
            count_next = count_reg;
            free_next  = free_reg;
            req.nxt_data = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            front_reg <= '0;
            back_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            op_reg    <= OP_SIZE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg <= arg_next;
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        k_reg   <= k_next;
        rv_reg  <= rv_next;
        st_reg  <= st_next;
        od_reg  <= od_next;
    end

    `BDL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CntW'(Capacity),
        "element count above capacity")
    `BDL_ASSERT_IMP(a_hold_out, ov_reg && !m_axis_tready, ov_next && od_next == od_reg,
        "result changed while stalled")
    `BDL_ASSERT_NEXT(a_push_grows, state_reg == S_PUSH, count_reg == $past(count_reg) + 1'b1,
        "push did not grow the count")
    `BDL_ASSERT_IMP(a_busy_no_ready, state_reg != S_IDLE, !s_axis_tready,
        "command taken while busy")
endmodule

FILE: bench/tb_bounded_doubly_linked_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_doubly_linked_list_unit
// Drives list commands and checks every result beat against a behavioral
// list model kept as a queue ordered from front to back.
// ----------------------------------------------------------------------------
module tb_bounded_doubly_linked_list_unit
    import bdll_pkg::*;
();

    typedef struct packed {
        logic [5:0]  position;
        logic [31:0] operand;
        logic [2:0]  opcode;
    } list_cmd_t;

    typedef struct packed {
        logic [6:0]  count;
        logic [2:0]  status;
        logic [31:0] value;
    } list_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    list_cmd_t   pending_cmds[$];
    list_rsp_t   expected_rsps[$];
    logic [31:0] list_contents[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          accepted_cmds;
    int          queued_cmds;
    bit          failed;

    bounded_doubly_linked_list_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one command to the list model and returns the result beat.
    function automatic list_rsp_t apply_list_cmd(list_cmd_t cmd);
        list_rsp_t rsp;
        int        hit;
        rsp = '0;
        rsp.status = ST_OK;
        case (cmd.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (list_contents.size() >= Capacity)
                    rsp.status = ST_FULL;
                else if (cmd.opcode == OP_PUSH_FRONT)
                    list_contents = {cmd.operand, list_contents};
                else
                    list_contents = {list_contents, cmd.operand};
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (list_contents.size() == 0)
                    rsp.status = ST_EMPTY;
                else if (cmd.opcode == OP_POP_FRONT)
                    list_contents.delete(0);
                else
                    list_contents.delete(list_contents.size() - 1);
            end
            OP_REMOVE:
            begin
                hit = -1;
                foreach (list_contents[i])
                    if (hit < 0 && list_contents[i] == cmd.operand)
                        hit = i;
                if (hit < 0)
                    rsp.status = ST_NOT_FOUND;
                else
                    list_contents.delete(hit);
            end
            OP_CLEAR:
                list_contents.delete();
            OP_GET:
            begin
                if (cmd.position >= list_contents.size())
                    rsp.status = ST_RANGE;
                else
                    rsp.value = list_contents[cmd.position];
            end
            default:
                ;
        endcase
        rsp.count = 7'(list_contents.size());
        return rsp;
    endfunction

    // Picks a value already in the list most of the time, so removes hit.
    function automatic logic [31:0] pick_value(int hit_pct);
        if (list_contents.size() > 0 && $urandom_range(99) < hit_pct)
            return list_contents[$urandom_range(list_contents.size() - 1)];
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Queues a command and updates the model at once; commands run in order.
    task automatic add_cmd(logic [2:0] op, logic [31:0] val, logic [5:0] pos);
        list_cmd_t cmd;
        cmd.opcode = op;
        cmd.operand = val;
        cmd.position = pos;
        pending_cmds = {pending_cmds, cmd};
        expected_rsps = {expected_rsps, apply_list_cmd(cmd)};
        queued_cmds++;
    endtask

    task automatic add_random_cmds(int num);
        int          roll;
        logic [2:0]  op;
        logic [5:0]  pos;
        for (int i = 0; i < num; i++)
        begin
            roll = $urandom_range(99);
            pos = 6'($urandom);
            if (roll < 20)
                op = OP_PUSH_FRONT;
            else if (roll < 42)
                op = OP_PUSH_BACK;
            else if (roll < 50)
                op = OP_POP_FRONT;
            else if (roll < 58)
                op = OP_POP_BACK;
            else if (roll < 72)
                op = OP_REMOVE;
            else if (roll < 74)
                op = OP_CLEAR;
            else if (roll < 94)
            begin
                op = OP_GET;
                // Mostly indexes inside the list, so most gets walk to a node.
                if (list_contents.size() > 0 && $urandom_range(3) != 0)
                    pos = 6'($urandom_range(list_contents.size() - 1));
            end
            else
                op = OP_SIZE;
            add_cmd(op, pick_value(70), pos);
        end
    endtask

    task automatic wait_drained();
        while (accepted_cmds < queued_cmds || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 75;
        accepted_cmds = 0;
        queued_cmds = 0;
        failed = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty cases, extremes, fill to full, overflow.
        add_cmd(OP_POP_FRONT, 0, 0);
        add_cmd(OP_POP_BACK, 0, 0);
        add_cmd(OP_REMOVE, 5, 0);
        add_cmd(OP_GET, 0, 0);
        add_cmd(OP_SIZE, 0, 0);
        add_cmd(OP_PUSH_FRONT, 32'h8000_0000, 0);
        add_cmd(OP_PUSH_BACK, 32'h7fff_ffff, 0);
        add_cmd(OP_PUSH_FRONT, 32'hffff_ffff, 0);
        add_cmd(OP_GET, 0, 2);
        add_cmd(OP_GET, 0, 3);
        add_cmd(OP_GET, 0, 6'h3f);
        add_cmd(OP_REMOVE, 32'h8000_0000, 0);
        add_cmd(OP_REMOVE, 32'h1234_5678, 0);
        add_cmd(OP_POP_BACK, 0, 0);
        add_cmd(OP_POP_FRONT, 0, 0);
        for (int i = 0; i < Capacity; i++)
            add_cmd((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, 0);
        add_cmd(OP_PUSH_BACK, 1, 0);
        add_cmd(OP_PUSH_FRONT, 2, 0);
        add_cmd(OP_GET, 0, 6'h3f);
        add_cmd(OP_REMOVE, list_contents[Capacity - 1], 0);
        add_cmd(OP_REMOVE, list_contents[30], 0);
        add_cmd(OP_CLEAR, 0, 0);
        add_cmd(OP_PUSH_BACK, 7, 0);
        add_cmd(OP_SIZE, 0, 0);
        wait_drained();

        add_random_cmds(400);
        wait_drained();
        send_idle_pct = 75;
        recv_idle_pct = 36;
        add_random_cmds(400);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_cmds(400);
        wait_drained();

        repeat (200) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Command driver: a beat stays up until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                accepted_cmds++;
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, pending_cmds[0]};
                pending_cmds.delete(0);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t got;
        list_rsp_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[41:0];
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (got.value !== want.value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.value, got.value);
                        failed = 1'b1;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        failed = 1'b1;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: element_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        failed = 1'b1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end
endmodule
